>>> hw/rtl/dss_pkg.sv
// shared types and constants of the delimited span stripper
package dss_pkg;

   localparam int DSS_DELIM_MAX = 4;
   localparam int DSS_ADDR_W    = 4;

   // register reset values
   localparam logic [2:0]  DSS_START_LEN_RST   = 3'd2;
   localparam logic [31:0] DSS_START_BYTES_RST = 32'h0000_2A2F;
   localparam logic [2:0]  DSS_END_LEN_RST     = 3'd2;
   localparam logic [31:0] DSS_END_BYTES_RST   = 32'h0000_2F2A;

   typedef enum logic [1:0] {
      REG_START_LEN   = 2'd0,
      REG_START_BYTES = 2'd1,
      REG_END_LEN     = 2'd2,
      REG_END_BYTES   = 2'd3
   } dss_reg_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } dss_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
   } dss_rsp_type;

   // span tracking flags carried between steps
   typedef struct packed {
      logic       in_span;
      logic       pass_next;
      logic [2:0] tail_left;
   } dss_ctl_type;

endpackage

>>> hw/rtl/dss_step.sv
// one-character step of the span stripper: window update and kept characters
module dss_step #(
   parameter int DelimMax = dss_pkg::DSS_DELIM_MAX
) (
   input  logic [7:0]                       in_byte,
   input  logic                             in_last,
   input  logic [2:0]                       start_len,
   input  logic [31:0]                      start_bytes,
   input  logic [2:0]                       end_len,
   input  logic [31:0]                      end_bytes,
   input  logic [DelimMax-1:0][7:0]         win_cur,
   input  logic [$clog2(DelimMax+1)-1:0]    fill_cur,
   input  dss_pkg::dss_ctl_type             ctl_cur,
   output logic [DelimMax-1:0][7:0]         win_nxt,
   output logic [$clog2(DelimMax+1)-1:0]    fill_nxt,
   output dss_pkg::dss_ctl_type             ctl_nxt,
   output logic [DelimMax-1:0][7:0]         res_bytes,
   output logic [$clog2(DelimMax+1)-1:0]    res_cnt
);
   import dss_pkg::*;

   localparam int FillW  = $clog2(DelimMax + 1);
   localparam int Rounds = DelimMax + 1;

   function automatic logic [2:0] eff_len(input logic [2:0] v);
      logic [2:0] r;
      r = v;
      if (v == 3'd0) begin
         r = 3'd1;
      end else if (int'(v) > DelimMax) begin
         r = 3'(DelimMax);
      end
      return r;
   endfunction

   function automatic logic win_match(input logic [DelimMax-1:0][7:0] w,
                                      input logic [FillW-1:0] f,
                                      input logic [31:0] bytes,
                                      input logic [2:0] len);
      logic ok;
      ok = (int'(f) >= int'(len));
      for (int k = 0; k < DelimMax; k++) begin
         // bytes past the register compare against zero
         if (k < int'(len) && w[k] != 8'(bytes >> (8 * k))) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [DelimMax-1:0][7:0] shift_win(input logic [DelimMax-1:0][7:0] w);
      logic [DelimMax-1:0][7:0] r;
      r = '0;
      for (int k = 0; k < DelimMax - 1; k++) begin
         r[k] = w[k + 1];
      end
      return r;
   endfunction

   logic [2:0]               slen;
   logic [2:0]               elen;
   logic [DelimMax-1:0][7:0] w;
   logic [FillW-1:0]         f;
   logic                     sp;
   logic                     ps;
   logic [2:0]               tl;
   logic [FillW-1:0]         n;
   logic [DelimMax-1:0][7:0] res;
   logic                     sh;
   logic                     em;

   always_comb begin
      slen = eff_len(start_len);
      elen = eff_len(end_len);
      w    = win_cur;
      f    = fill_cur;
      sp   = ctl_cur.in_span;
      ps   = ctl_cur.pass_next;
      tl   = ctl_cur.tail_left;
      n    = '0;
      res  = '0;
      sh   = 1'b0;
      em   = 1'b0;

      // append the new character
      if (int'(f) < DelimMax) begin
         for (int k = 0; k < DelimMax; k++) begin
            if (k == int'(f)) begin
               w[k] = in_byte;
            end
         end
         f = f + FillW'(1);
      end

      // each round retires at most one character or settles
      for (int r = 0; r < Rounds; r++) begin
         sh = 1'b0;
         em = 1'b0;
         if (ps) begin
            if (f != '0) begin
               em = 1'b1;
               sh = 1'b1;
               ps = 1'b0;
            end
         end else begin
            if (!sp && tl == 3'd0 && int'(f) >= int'(slen)) begin
               if (win_match(w, f, start_bytes, slen)) begin
                  sp = 1'b1;
               end else begin
                  em = 1'b1;
                  sh = 1'b1;
               end
            end
            // end delimiter is searched from the start position
            if (!sh && sp && tl == 3'd0 && int'(f) >= int'(elen)) begin
               if (win_match(w, f, end_bytes, elen)) begin
                  tl = elen;
               end else begin
                  sh = 1'b1;
               end
            end
            if (!sh && tl != 3'd0 && f != '0) begin
               sh = 1'b1;
               tl = tl - 3'd1;
               if (tl == 3'd0) begin
                  sp = 1'b0;
                  ps = 1'b1;
               end
            end
         end
         if (em) begin
            for (int k = 0; k < DelimMax; k++) begin
               if (k == int'(n)) begin
                  res[k] = w[0];
               end
            end
            n = n + FillW'(1);
         end
         if (sh) begin
            w = shift_win(w);
            f = f - FillW'(1);
         end
      end

      // end of string: flush pending characters unless inside a span
      if (in_last) begin
         if (!sp && tl == 3'd0) begin
            for (int k = 0; k < DelimMax; k++) begin
               if (k < int'(f)) begin
                  for (int j = 0; j < DelimMax; j++) begin
                     if (j == int'(n)) begin
                        res[j] = w[k];
                     end
                  end
                  n = n + FillW'(1);
               end
            end
         end
         w  = '0;
         f  = '0;
         sp = 1'b0;
         ps = 1'b0;
         tl = 3'd0;
      end

      win_nxt           = w;
      fill_nxt          = f;
      ctl_nxt.in_span   = sp;
      ctl_nxt.pass_next = ps;
      ctl_nxt.tail_left = tl;
      res_bytes         = res;
      res_cnt           = n;
   end

endmodule

>>> hw/rtl/delimited_span_stripper.sv
// top level of the delimited span stripper: registers, handshakes and result buffer
//
//   channel  | ports                           | moves
//   ---------+---------------------------------+---------------------------------
//   request  | req_valid req_ready req_payload | one character and its last flag
//   response | rsp_valid rsp_ready rsp_payload | one kept character or empty end
//   config   | psel penable pwrite paddr ...   | 32-bit register writes and reads
//
// a character is processed combinationally while it sits in the input register;
// each character yields 0 to DelimMax response beats, shown one per cycle while rsp_ready is high
// a new request beat is taken every cycle while each character yields at most
// one beat and rsp_ready stays high; a character yielding more beats holds the input
// reset is synchronous, loads the register reset values and clears stream state and buffers
// a stall on the response side backs up into req_ready through the input register
module delimited_span_stripper #(
   parameter int DelimMax = dss_pkg::DSS_DELIM_MAX
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dss_pkg::dss_req_type              req_payload,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dss_pkg::dss_rsp_type              rsp_payload,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dss_pkg::DSS_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import dss_pkg::*;

   localparam int FillW = $clog2(DelimMax + 1);

   // configuration registers
   logic [2:0]  start_len_ff;
   logic [31:0] start_bytes_ff;
   logic [2:0]  end_len_ff;
   logic [31:0] end_bytes_ff;

   // input register
   logic        in_valid_ff;
   dss_req_type in_data_ff;

   // stream state: lookahead window, fill and span flags
   logic [DelimMax-1:0][7:0] win_ff;
   logic [FillW-1:0]         fill_ff;
   dss_ctl_type              ctl_ff;

   // result buffer drained one beat per cycle while rsp_ready is high
   logic [DelimMax-1:0][7:0] bat_bytes_ff;
   logic [FillW-1:0]         bat_cnt_ff;
   logic                     bat_has_ff;
   logic                     bat_last_ff;

   logic [DelimMax-1:0][7:0] win_in;
   logic [FillW-1:0]         fill_in;
   dss_ctl_type              ctl_in;
   logic [DelimMax-1:0][7:0] res_bytes;
   logic [FillW-1:0]         res_cnt;
   logic [DelimMax-1:0][7:0] bat_shift;

   logic cfg_write;
   logic batch_free;
   logic need_batch;
   logic empty_last;
   logic consume;
   logic rsp_take;

   dss_step #(
      .DelimMax (DelimMax)
   ) u_step (
      .in_byte     (in_data_ff.in_byte),
      .in_last     (in_data_ff.in_last),
      .start_len   (start_len_ff),
      .start_bytes (start_bytes_ff),
      .end_len     (end_len_ff),
      .end_bytes   (end_bytes_ff),
      .win_cur     (win_ff),
      .fill_cur    (fill_ff),
      .ctl_cur     (ctl_ff),
      .win_nxt     (win_in),
      .fill_nxt    (fill_in),
      .ctl_nxt     (ctl_in),
      .res_bytes   (res_bytes),
      .res_cnt     (res_cnt)
   );

   // register port: no wait states
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (dss_reg_type'(paddr[3:2]))
         REG_START_LEN:   prdata = {29'd0, start_len_ff};
         REG_START_BYTES: prdata = start_bytes_ff;
         REG_END_LEN:     prdata = {29'd0, end_len_ff};
         REG_END_BYTES:   prdata = end_bytes_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_len_ff   <= DSS_START_LEN_RST;
         start_bytes_ff <= DSS_START_BYTES_RST;
         end_len_ff     <= DSS_END_LEN_RST;
         end_bytes_ff   <= DSS_END_BYTES_RST;
      end else if (cfg_write) begin
         unique case (dss_reg_type'(paddr[3:2]))
            REG_START_LEN:   start_len_ff   <= pwdata[2:0];
            REG_START_BYTES: start_bytes_ff <= pwdata;
            REG_END_LEN:     end_len_ff     <= pwdata[2:0];
            REG_END_BYTES:   end_bytes_ff   <= pwdata;
         endcase
      end
   end

   // buffer can take a new batch when empty or its final beat leaves now
   assign rsp_take   = rsp_valid && rsp_ready;
   assign batch_free = (bat_cnt_ff == '0) || (bat_cnt_ff == FillW'(1) && rsp_ready);
   // an end of string with nothing kept still produces one empty beat
   assign empty_last = in_data_ff.in_last && (res_cnt == '0);
   assign need_batch = (res_cnt != '0) || in_data_ff.in_last;
   // a character with no beats never waits for the buffer
   assign consume    = in_valid_ff && (batch_free || !need_batch);
   assign req_ready  = !in_valid_ff || consume;

   always_comb begin
      bat_shift = '0;
      for (int k = 0; k < DelimMax - 1; k++) begin
         bat_shift[k] = bat_bytes_ff[k + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         fill_ff     <= '0;
         ctl_ff      <= '0;
         bat_cnt_ff  <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (consume) begin
            fill_ff <= fill_in;
            ctl_ff  <= ctl_in;
         end
         if (consume && need_batch) begin
            bat_cnt_ff <= empty_last ? FillW'(1) : res_cnt;
         end else if (rsp_take) begin
            bat_cnt_ff <= bat_cnt_ff - FillW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_payload;
      end
      if (consume) begin
         win_ff <= win_in;
      end
      if (consume && need_batch) begin
         bat_bytes_ff <= res_bytes;
         bat_has_ff   <= !empty_last;
         bat_last_ff  <= in_data_ff.in_last;
      end else if (rsp_take) begin
         bat_bytes_ff <= bat_shift;
      end
   end

   assign rsp_valid            = (bat_cnt_ff != '0);
   assign rsp_payload.out_byte = bat_bytes_ff[0];
   assign rsp_payload.has_byte = bat_has_ff;
   assign rsp_payload.out_last = bat_last_ff && (bat_cnt_ff == FillW'(1));

   // buffer never holds more beats than the window depth
   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      int'(bat_cnt_ff) <= DelimMax)
      else $error("result buffer count above window depth");

   // between characters the window always has room for the next one
   a_window_room: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) < DelimMax)
      else $error("lookahead window full between characters");

   a_span_pass_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl_ff.in_span && ctl_ff.pass_next))
      else $error("span and pass-through flags both set");

   // end of string returns the stream to its idle state
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (consume && in_data_ff.in_last) |=>
      (fill_ff == '0 && !ctl_ff.in_span && !ctl_ff.pass_next && ctl_ff.tail_left == 3'd0))
      else $error("stream state not cleared after last character");

endmodule

>>> verif/dss_strip_check_pkg.sv
// scoreboard class that predicts the stripped character stream and checks response beats
`timescale 1ns / 100ps
package dss_strip_check_pkg;
   import dss_pkg::*;

   class strip_scoreboard;
      // delimiter register mirror
      logic [2:0]  open_len    = DSS_START_LEN_RST;
      logic [31:0] open_delim  = DSS_START_BYTES_RST;
      logic [2:0]  close_len   = DSS_END_LEN_RST;
      logic [31:0] close_delim = DSS_END_BYTES_RST;

      // stream state
      logic [7:0]  look [DSS_DELIM_MAX];
      int unsigned look_fill;
      bit          in_span;
      int unsigned tail_left;
      bit          pass_next;

      dss_rsp_type step_q[$];
      dss_rsp_type kept_q[$];
      int          errors;

      function new();
         clear_stream();
      endfunction

      function void clear_stream();
         foreach (look[k]) look[k] = 8'd0;
         look_fill = 0;
         in_span   = 1'b0;
         tail_left = 0;
         pass_next = 1'b0;
      endfunction

      function void write_reg(dss_reg_type idx, logic [31:0] value);
         case (idx)
            REG_START_LEN:   open_len    = value[2:0];
            REG_START_BYTES: open_delim  = value;
            REG_END_LEN:     close_len   = value[2:0];
            REG_END_BYTES:   close_delim = value;
            default: ;
         endcase
      endfunction

      // zero acts as one, anything above the window depth is clamped
      function int unsigned eff_len(logic [2:0] v);
         if (v == 3'd0) return 1;
         if (v > DSS_DELIM_MAX) return DSS_DELIM_MAX;
         return v;
      endfunction

      function bit window_hit(logic [31:0] delim, int unsigned len);
         if (look_fill < len) return 1'b0;
         for (int unsigned k = 0; k < len; k++)
            if (look[k] != delim[8*k +: 8]) return 1'b0;
         return 1'b1;
      endfunction

      function void drop_head();
         if (look_fill == 0) return;
         for (int unsigned k = 1; k < look_fill; k++) look[k-1] = look[k];
         look_fill--;
         look[look_fill] = 8'd0;
      endfunction

      function void keep_head();
         dss_rsp_type beat;
         beat.out_byte = look[0];
         beat.has_byte = 1'b1;
         beat.out_last = 1'b0;
         step_q.push_back(beat);
         drop_head();
      endfunction

      // one accepted character: work out the beats it releases
      function void note_char(dss_req_type item);
         int unsigned slen;
         int unsigned elen;
         dss_rsp_type beat;
         slen = eff_len(open_len);
         elen = eff_len(close_len);
         step_q.delete();
         if (look_fill < DSS_DELIM_MAX) begin
            look[look_fill] = item.in_byte;
            look_fill++;
         end
         while (1'b1) begin
            if (tail_left > 0) begin
               // swallowing the closing delimiter
               if (look_fill == 0) break;
               drop_head();
               tail_left--;
               if (tail_left == 0) begin
                  in_span   = 1'b0;
                  pass_next = 1'b1;
               end
            end else if (in_span) begin
               if (look_fill < elen) break;
               if (window_hit(close_delim, elen)) tail_left = elen;
               else drop_head();
            end else if (pass_next) begin
               // character after a span goes out without an opener test
               if (look_fill == 0) break;
               keep_head();
               pass_next = 1'b0;
            end else begin
               if (look_fill < slen) break;
               if (window_hit(open_delim, slen)) in_span = 1'b1;
               else keep_head();
            end
         end
         if (item.in_last) begin
            if (!in_span && tail_left == 0)
               while (look_fill > 0) keep_head();
            if (step_q.size() > 0) begin
               step_q[step_q.size()-1].out_last = 1'b1;
            end else begin
               beat = '0;
               beat.out_last = 1'b1;
               step_q.push_back(beat);
            end
            clear_stream();
         end
         foreach (step_q[i]) kept_q.push_back(step_q[i]);
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_beat(dss_rsp_type got);
         dss_rsp_type want;
         if (kept_q.size() == 0) begin
            note_error($sformatf("unexpected beat byte=%h has=%b last=%b",
                                 got.out_byte, got.has_byte, got.out_last));
            return;
         end
         want = kept_q.pop_front();
         if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
             got.out_last !== want.out_last)
            note_error($sformatf("byte exp %h got %h, has exp %b got %b, last exp %b got %b",
                                 want.out_byte, got.out_byte, want.has_byte, got.has_byte,
                                 want.out_last, got.out_last));
      endfunction

      function int pending();
         return kept_q.size();
      endfunction
   endclass

endpackage

>>> verif/delimited_span_stripper_tb.sv
// top level testbench of the delimited span stripper with stimulus, handshakes and end check
`timescale 1ns / 100ps
module delimited_span_stripper_tb;
   import dss_pkg::*;
   import dss_strip_check_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   dss_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   dss_rsp_type           rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [DSS_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   strip_scoreboard sb = new();

   int unsigned sent_chars;
   int unsigned rsp_hold_cycles;   // one-shot long stall asked of the receiver
   bit          req_no_idle;       // sender offers back to back
   bit          rsp_no_idle;       // receiver always ready
   logic [7:0]  line_q[$];         // characters of the string being built

   delimited_span_stripper dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register write: setup cycle, then access until pready
   task automatic csr_write(dss_reg_type idx, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic set_delims(logic [2:0] slen, logic [31:0] sbytes,
                             logic [2:0] elen, logic [31:0] ebytes);
      csr_write(REG_START_LEN, {29'd0, slen});
      csr_write(REG_START_BYTES, sbytes);
      csr_write(REG_END_LEN, {29'd0, elen});
      csr_write(REG_END_BYTES, ebytes);
   endtask

   // one request beat; valid stays up across back-to-back beats
   task automatic send_char(logic [7:0] ch, logic last);
      int unsigned gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{in_byte: ch, in_last: last};
      do @(posedge clock); while (!req_ready);
      sb.note_char(req_payload);
      sent_chars++;
   endtask

   // stop offering and wait for every predicted beat, then let the pipe settle
   task automatic drain_results(int unsigned settle);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic send_word(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // mostly delimiter characters so spans open and close often
   function automatic logic [7:0] text_char();
      logic [31:0] pool;
      logic [7:0]  c;
      pool = $urandom_range(0, 1) ? sb.open_delim : sb.close_delim;
      c = pool[8*$urandom_range(0, 3) +: 8];
      if ($urandom_range(0, 2) == 0 || c == 8'd0) c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   function automatic void add_text(int unsigned n);
      repeat (n) line_q.push_back(text_char());
   endfunction

   // zero delimiter bytes cannot be sent, a random character stands in
   function automatic void add_delim(logic [31:0] d, int unsigned n);
      logic [7:0] c;
      for (int unsigned k = 0; k < n; k++) begin
         c = d[8*k +: 8];
         if (c == 8'd0) c = 8'($urandom_range(1, 255));
         line_q.push_back(c);
      end
   endfunction

   // a string of a few segments: spans, plain text, openers without closers
   task automatic send_line(int unsigned segs);
      int unsigned slen;
      int unsigned elen;
      slen = sb.eff_len(sb.open_len);
      elen = sb.eff_len(sb.close_len);
      line_q.delete();
      repeat (segs) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               add_text($urandom_range(0, 3));
               add_delim(sb.open_delim, slen);
               add_text($urandom_range(0, 4));
               add_delim(sb.close_delim, elen);
            end
            6, 7: add_text($urandom_range(1, 6));
            8: begin
               add_delim(sb.open_delim, slen);
               add_text($urandom_range(0, 3));
            end
            default: add_delim(sb.open_delim, $urandom_range(1, slen));
         endcase
      end
      if (line_q.size() == 0) add_text(1);
      foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
   endtask

   // raw noise over the nonzero character range
   task automatic send_noise(int unsigned n);
      for (int unsigned i = 0; i < n; i++) send_char(8'($urandom_range(1, 255)), i == n - 1);
   endtask

   task automatic run_phase(int unsigned n_chars);
      int unsigned target;
      target = sent_chars + n_chars;
      while (sent_chars < target) begin
         if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 8));
         else send_line($urandom_range(1, 4));
      end
   endtask

   // response side: random stall before each beat, plus a one-shot long hold-off
   initial begin : rsp_side
      int unsigned stall;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         stall = rsp_no_idle ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_beat(rsp_payload);
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed strings on the reset delimiters, opener and closer of c comments
      send_word("a/");         // short tail flushed at the end
      send_word("/*x*/b");     // span removed, following character kept
      send_word("/*/");        // closer overlaps opener, nothing kept
      send_word("/*ab");       // unterminated span dropped
      send_char(8'hFF, 1'b0);  // field extremes
      send_char(8'h01, 1'b1);
      send_word("/**//*q");    // character after a span skips the opener test
      drain_results(12);

      // length zero acts as one, single character delimiters
      set_delims(3'd0, 32'h0000_0023, 3'd1, 32'h0000_000A);
      run_phase(30);
      drain_results(12);

      // oversize lengths clamp to the window, identical opener and closer, no idling
      req_no_idle = 1'b1;
      rsp_no_idle = 1'b1;
      set_delims(3'd7, 32'h4443_4241, 3'd7, 32'h4443_4241);
      run_phase(35);
      drain_results(12);
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;

      // all ones delimiters, sender pauses midway until every beat is back
      set_delims(3'd4, 32'hFFFF_FFFF, 3'd1, 32'hFFFF_FFFF);
      run_phase(15);
      drain_results(0);
      run_phase(15);
      drain_results(12);

      // all zero delimiters never match a nonzero character
      set_delims(3'd3, 32'h0000_0000, 3'd4, 32'h0000_0000);
      run_phase(30);
      drain_results(12);

      // random delimiters
      set_delims(3'($urandom_range(1, 4)), $urandom(), 3'($urandom_range(1, 4)), $urandom());
      run_phase(35);
      drain_results(12);

      // markup style comments while the receiver holds off and the sender keeps pushing
      set_delims(3'd2, 32'h0000_213C, 3'd3, 32'h003E_2D2D);
      req_no_idle = 1'b1;
      rsp_hold_cycles = 80;
      run_phase(45);
      req_no_idle = 1'b0;
      drain_results(20);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_step.sv
hw/rtl/delimited_span_stripper.sv
verif/dss_strip_check_pkg.sv
verif/delimited_span_stripper_tb.sv
